// File: rtl/sact_pkg.sv
// shared constants, types and helper functions of the cache tag controller
package sact_pkg;

    localparam int WAYS     = 8;
    localparam int SETS     = 1024;
    localparam int TAG_BITS = 16;

    localparam int IN_SET_W  = 10;
    localparam int IN_TAG_W  = 16;
    localparam int OUT_WAY_W = 3;

    localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W = $clog2(WAYS);

    typedef logic [WAYS-1:0][TAG_BITS-1:0] t_tag_row;

    typedef struct packed {
        logic [WAYS-1:0] valid;
        logic [WAYS-1:0] dirty;
        logic [WAYS-1:0] used;
    } t_stat_row;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP
    } t_state;

    typedef struct packed {
        logic clr;
        logic idle;
        logic load;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic out_free;
    } t_sts;

    function automatic logic [WAY_W-1:0] first_one(input logic [WAYS-1:0] vec);
        logic [WAY_W-1:0] idx;
        idx = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (vec[w]) begin
                idx = WAY_W'(w);
            end
        end
        return idx;
    endfunction

endpackage

// File: rtl/sact_if.sv
// request and response channel interfaces
interface sact_req_if;
    import sact_pkg::*;
    logic                valid;
    logic                ready;
    logic                action;
    logic [IN_SET_W-1:0] set_index;
    logic [IN_TAG_W-1:0] tag;

    modport source(output valid, action, set_index, tag, input ready);
    modport sink(input valid, action, set_index, tag, output ready);
endinterface

interface sact_rsp_if;
    import sact_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic [OUT_WAY_W-1:0] way;
    logic                 evicted;
    logic                 writeback;

    modport source(output valid, hit, way, evicted, writeback, input ready);
    modport sink(input valid, hit, way, evicted, writeback, output ready);
endinterface

// File: rtl/sact_ctrl.sv
// controller state machine: clearing pass, accept and lookup/update sequencing
module sact_ctrl import sact_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.idle = 1'b1;
                o_cmd.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

// File: rtl/sact_dp.sv
// datapath: set memories, tag compare, victim choice and result register
module sact_dp import sact_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  logic                 i_action,
    input  logic [IN_SET_W-1:0]  i_set_index,
    input  logic [IN_TAG_W-1:0]  i_tag,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic                 o_hit,
    output logic [OUT_WAY_W-1:0] o_way,
    output logic                 o_evicted,
    output logic                 o_writeback
);

    t_tag_row  r_tag_mem  [SETS];
    t_stat_row r_stat_mem [SETS];

    t_tag_row      r_tag_rd;
    t_stat_row     r_stat_rd;
    logic [SET_W-1:0]    r_clr_idx;
    logic [SET_W-1:0]    r_set;
    logic [TAG_BITS-1:0] r_tag;
    logic                r_write;

    logic                 r_out_valid;
    logic                 r_hit;
    logic [OUT_WAY_W-1:0] r_way;
    logic                 r_evicted;
    logic                 r_writeback;

    logic [SET_W-1:0] rd_addr;
    logic [SET_W-1:0] in_set;
    logic [SET_W-1:0] st_waddr;
    t_stat_row        n_stat;
    t_stat_row        st_wdata;
    t_tag_row         n_tags;
    logic [WAYS-1:0]  match;
    logic             hit;
    logic             any_inv;
    logic             any_unused;
    logic             evicted;
    logic             writeback;
    logic [WAY_W-1:0] way;

    assign in_set  = SET_W'(i_set_index % SETS);
    assign rd_addr = i_cmd.load ? in_set : r_set;

    assign o_sts.clr_last = (r_clr_idx == SET_W'(SETS - 1));
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            match[w] = r_stat_rd.valid[w] && (r_tag_rd[w] == r_tag);
        end
        hit        = |match;
        any_inv    = ~&r_stat_rd.valid;
        any_unused = ~&r_stat_rd.used;
        evicted    = 1'b0;
        writeback  = 1'b0;
        n_stat     = r_stat_rd;
        n_tags     = r_tag_rd;
        if (hit) begin
            way                 = first_one(match);
            n_stat.used[way]    = 1'b1;
            n_stat.dirty[way]   = r_stat_rd.dirty[way] | r_write;
        end else begin
            priority if (any_inv) begin
                way = first_one(~r_stat_rd.valid);
            end else if (any_unused) begin
                way = first_one(~r_stat_rd.used);
            end else begin
                way         = '0;
                n_stat.used = '0;
            end
            evicted           = !any_inv;
            writeback         = evicted && r_stat_rd.dirty[way];
            n_stat.valid[way] = 1'b1;
            n_stat.used[way]  = 1'b1;
            n_stat.dirty[way] = r_write;
            n_tags[way]       = r_tag;
        end
    end

    assign st_waddr = i_cmd.clr ? r_clr_idx : r_set;
    assign st_wdata = i_cmd.clr ? '0 : n_stat;

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr || i_cmd.commit) begin
            r_stat_mem[st_waddr] <= st_wdata;
        end
        r_stat_rd <= r_stat_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && !hit) begin
            r_tag_mem[r_set] <= n_tags;
        end
        r_tag_rd <= r_tag_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_cmd.clr) begin
            r_clr_idx <= r_clr_idx + SET_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_set   <= in_set;
            r_tag   <= i_tag[TAG_BITS-1:0];
            r_write <= i_action;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_hit       <= hit;
            r_way       <= OUT_WAY_W'(way);
            r_evicted   <= evicted;
            r_writeback <= writeback;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_hit       = r_hit;
    assign o_way       = r_way;
    assign o_evicted   = r_evicted;
    assign o_writeback = r_writeback;

endmodule

// File: rtl/set_assoc_cache_tag_controller.sv
// top level of the set-associative cache tag controller
// An access word (read or write, set index, tag) is taken, and one result word
// (hit, way, evicted, writeback) comes back for it. Each access goes through two steps:
// one to accept it and read the set's tag and status rows from the on-chip
// memories, one to compare all ways in parallel, pick the victim and write the
// updated rows back. The next access is taken in the cycle after that, while
// the result still waits in the output register; a lookup holds only when that
// register is full and not being taken. After reset a clearing pass zeroes the
// valid, dirty and used bits one set a cycle, all 1024 sets, with ready low.
module set_assoc_cache_tag_controller import sact_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sact_req_if.sink    i_req,
    sact_rsp_if.source  o_rsp
);

    t_cmd cmd;
    t_sts sts;

    assign i_req.ready = cmd.idle;

    sact_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sact_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_action    (i_req.action),
        .i_set_index (i_req.set_index),
        .i_tag       (i_req.tag),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .o_hit       (o_rsp.hit),
        .o_way       (o_rsp.way),
        .o_evicted   (o_rsp.evicted),
        .o_writeback (o_rsp.writeback)
    );

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |=> o_rsp.valid)
        else $error("result word missing after update");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !(o_rsp.hit && o_rsp.evicted))
        else $error("eviction reported on a hit");

    a_wb_needs_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.writeback) |-> o_rsp.evicted)
        else $error("writeback without eviction");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("second access taken during lookup");

endmodule

// File: dv/sact_checker.sv
// result checker for the cache tag controller: own copy of the state, prediction, compare
module sact_checker import sact_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sact_req_if         i_req,
    sact_rsp_if         i_rsp,
    output int unsigned o_fail_count,
    output int unsigned o_pending,
    output int unsigned o_checked,
    output int unsigned o_hits,
    output int unsigned o_evictions,
    output int unsigned o_writebacks
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                 hit;
        logic [OUT_WAY_W-1:0] way;
        logic                 evicted;
        logic                 writeback;
    } t_lookup_result;

    logic [TAG_BITS-1:0] line_tag_copy [SETS][WAYS];
    logic [WAYS-1:0]     valid_row [SETS];
    logic [WAYS-1:0]     dirty_row [SETS];
    logic [WAYS-1:0]     used_row  [SETS];

    t_lookup_result lookups_in_flight [$];

    int unsigned fail_count;
    int unsigned pending_count;
    int unsigned checked_count;
    int unsigned hit_count;
    int unsigned evict_count;
    int unsigned writeback_count;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;
    assign o_checked    = checked_count;
    assign o_hits       = hit_count;
    assign o_evictions  = evict_count;
    assign o_writebacks = writeback_count;

    function automatic t_lookup_result cache_lookup(
        input logic                is_write,
        input logic [IN_SET_W-1:0] set_in,
        input logic [IN_TAG_W-1:0] tag_in
    );
        t_lookup_result      res;
        int                  s;
        int                  hit_way;
        int                  victim;
        logic [TAG_BITS-1:0] t;
        s       = int'(set_in) % SETS;
        t       = TAG_BITS'(tag_in);
        res     = '0;
        hit_way = -1;
        victim  = -1;
        for (int w = 0; w < WAYS; w++) begin
            if (hit_way < 0 && valid_row[s][w] && line_tag_copy[s][w] == t) begin
                hit_way = w;
            end
        end
        if (hit_way >= 0) begin
            res.hit = 1'b1;
            res.way = OUT_WAY_W'(hit_way);
            used_row[s][hit_way] = 1'b1;
            if (is_write) begin
                dirty_row[s][hit_way] = 1'b1;
            end
        end else begin
            for (int w = 0; w < WAYS; w++) begin
                if (victim < 0 && !valid_row[s][w]) begin
                    victim = w;
                end
            end
            if (victim < 0) begin
                res.evicted = 1'b1;
                for (int w = 0; w < WAYS; w++) begin
                    if (victim < 0 && !used_row[s][w]) begin
                        victim = w;
                    end
                end
                // every way recently used: start a new round at way 0
                if (victim < 0) begin
                    used_row[s] = '0;
                    victim      = 0;
                end
                res.writeback = dirty_row[s][victim];
            end
            res.way                 = OUT_WAY_W'(victim);
            valid_row[s][victim]    = 1'b1;
            used_row[s][victim]     = 1'b1;
            dirty_row[s][victim]    = is_write;
            line_tag_copy[s][victim] = t;
        end
        return res;
    endfunction

    function automatic void report_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%t mismatch: %s", $realtime, msg);
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_lookup_result got;
        t_lookup_result want;
        if (!i_rst_n) begin
            for (int s = 0; s < SETS; s++) begin
                valid_row[s] = '0;
                dirty_row[s] = '0;
                used_row[s]  = '0;
            end
            lookups_in_flight.delete();
            fail_count      = 0;
            checked_count   = 0;
            hit_count       = 0;
            evict_count     = 0;
            writeback_count = 0;
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                got.hit       = i_rsp.hit;
                got.way       = i_rsp.way;
                got.evicted   = i_rsp.evicted;
                got.writeback = i_rsp.writeback;
                checked_count++;
                if (lookups_in_flight.size() == 0) begin
                    report_failure($sformatf(
                        "result word with no access outstanding: hit=%b way=%0d ev=%b wb=%b",
                        got.hit, got.way, got.evicted, got.writeback));
                end else begin
                    want = lookups_in_flight.pop_front();
                    if (want.hit)       hit_count++;
                    if (want.evicted)   evict_count++;
                    if (want.writeback) writeback_count++;
                    if (got !== want) begin
                        report_failure($sformatf(
                            "want hit=%b way=%0d ev=%b wb=%b, got hit=%b way=%0d ev=%b wb=%b",
                            want.hit, want.way, want.evicted, want.writeback,
                            got.hit, got.way, got.evicted, got.writeback));
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                lookups_in_flight.push_back(
                    cache_lookup(i_req.action, i_req.set_index, i_req.tag));
            end
        end
        pending_count = lookups_in_flight.size();
    end

endmodule

// File: dv/set_assoc_cache_tag_controller_tb.sv
// testbench top for the cache tag controller: clock, reset, access stimulus and verdict
module set_assoc_cache_tag_controller_tb import sact_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic ACT_READ    = 1'b0;
    localparam logic ACT_WRITE   = 1'b1;
    localparam int   N_RANDOM    = 425;
    localparam int   IDLE_PCT    = 8;
    localparam int   HOLD_CYCLES = 80;
    localparam int   DRAIN_WAIT  = 20;
    localparam int   N_HOT_SETS  = 4;
    localparam int   N_HOT_TAGS  = 12;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic quiet        = 1'b0;
    logic hold_request = 1'b0;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned checked;
    int unsigned hits;
    int unsigned evictions;
    int unsigned writebacks;

    sact_req_if req_bus ();
    sact_rsp_if rsp_bus ();

    set_assoc_cache_tag_controller DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    sact_checker u_result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_bus),
        .i_rsp        (rsp_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_hits       (hits),
        .o_evictions  (evictions),
        .o_writebacks (writebacks)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #1ms;
        $display("set_assoc_cache_tag_controller test failed");
        $finish;
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        forever begin
            if (hold_request) begin
                rsp_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end else begin
                rsp_bus.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
                @(posedge i_clk);
            end
        end
    end

    task automatic send_access(
        input logic                act,
        input logic [IN_SET_W-1:0] set_idx,
        input logic [IN_TAG_W-1:0] tag_val
    );
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            req_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_bus.valid     <= 1'b1;
        req_bus.action    <= act;
        req_bus.set_index <= set_idx;
        req_bus.tag       <= tag_val;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [IN_SET_W-1:0] hot_sets [N_HOT_SETS];
        logic [IN_TAG_W-1:0] hot_tags [N_HOT_TAGS];
        i_rst_n           <= 1'b0;
        req_bus.valid     <= 1'b0;
        req_bus.action    <= ACT_READ;
        req_bus.set_index <= '0;
        req_bus.tag       <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // fill set 0, hit, then replacement after all used bits are set
        for (int w = 0; w < WAYS - 1; w++) begin
            send_access(ACT_READ, '0, IN_TAG_W'(w));
        end
        send_access(ACT_WRITE, '0, '1);
        send_access(ACT_WRITE, '0, '0);
        send_access(ACT_READ, '0, 16'h1234);
        send_access(ACT_READ, '0, 16'h4321);
        send_access(ACT_WRITE, '0, 16'h4321);
        // victims from the first clear used bit, last one dirty
        for (int w = 0; w < WAYS - 2; w++) begin
            send_access(ACT_READ, '0, IN_TAG_W'(16'h0100 + w));
        end
        send_access(ACT_WRITE, '1, '1);
        send_access(ACT_READ, '1, '1);
        send_access(ACT_READ, '1, 16'h7FFF);
        send_access(ACT_WRITE, 10'h155, 16'hAAAA);
        send_access(ACT_READ, 10'h2AA, 16'h5555);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 100 == 0) begin
                foreach (hot_sets[i]) hot_sets[i] = IN_SET_W'($urandom_range(SETS - 1));
                foreach (hot_tags[i]) hot_tags[i] = IN_TAG_W'($urandom_range(16'hFFFF));
            end
            quiet = (n >= 150 && n < 290);
            if (n == 60) begin
                hold_request = 1'b1;
            end
            if (n == 300) begin
                req_bus.valid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            if ($urandom_range(99) < 20) begin
                send_access(1'($urandom_range(1)), IN_SET_W'($urandom_range(SETS - 1)),
                            IN_TAG_W'($urandom_range(16'hFFFF)));
            end else begin
                send_access(1'($urandom_range(1)), hot_sets[$urandom_range(N_HOT_SETS - 1)],
                            hot_tags[$urandom_range(N_HOT_TAGS - 1)]);
            end
        end
        quiet = 1'b0;
        req_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("covered %0d accesses: %0d hits, %0d evictions, %0d writebacks",
                 checked, hits, evictions, writebacks);
        $display("traffic: fill and replacement cases, hot-set mix, result hold-off, drain pause");
        if (fail_count == 0) begin
            $display("set_assoc_cache_tag_controller test passed");
        end else begin
            $display("set_assoc_cache_tag_controller test failed");
        end
        $finish;
    end

endmodule

// File: set_assoc_cache_tag_controller.f
rtl/sact_pkg.sv
rtl/sact_if.sv
rtl/sact_ctrl.sv
rtl/sact_dp.sv
rtl/set_assoc_cache_tag_controller.sv
dv/sact_checker.sv
dv/set_assoc_cache_tag_controller_tb.sv
